### src/imh_pkg.sv
// types and constants shared by the indexed max-heap
package imh_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = 6;
  localparam int ID_COUNT = 1 << ID_W;
  localparam int SLOT_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = 7;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DUP    = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_DELETE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DLOAD,
    S_UP,
    S_DOWN,
    S_PLACE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic            tag;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage

### src/indexed_max_heap.sv
// indexed binary max-heap of identifiers with a per-entry tag
//
// usage
// - an item (func_i, item_id_i, tag_bit_i) is taken at a rising edge with start high
//   and busy low; func_i selects insert of item_id_i with tag_bit_i, or delete of
//   item_id_i wherever it sits in the heap
// - each item gives exactly one result: done_o is high for one cycle and the result
//   ports (top entry, entry count, status) are valid in that cycle only
// - the receiver cannot hold a result off; busy stays high until the result is out
// - order of work: a rejected item goes from the check straight to the result; an
//   insert into an empty heap or a delete of the last slot needs no walk; else an insert
//   walks up, and a delete loads the last entry, then walks up or down, one heap level
//   per step, before placing; a new item can be taken in the idle cycle after done_o
// - the walk is one comparison per cycle through the two-read-port heap memory, one
//   level per cycle; the moving entry stays in a register and only the displaced entry
//   is written each cycle, so a swap costs one write to each memory
// - reset clears the entry count and the presence bits, so the heap is empty and no
//   memory clearing pass is needed; heap memory contents are don't-care until written
// - rejected items (insert when full, duplicate insert, delete of an absent id) leave
//   the heap untouched and only set the status
module indexed_max_heap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic [imh_pkg::ID_W-1:0]      item_id_i,
  input  logic                          tag_bit_i,
  output logic                          done_o,
  output logic                          top_valid_o,
  output logic [imh_pkg::ID_W-1:0]      top_id_o,
  output logic                          top_tag_o,
  output logic [imh_pkg::COUNT_W-1:0]   entry_count_o,
  output logic [1:0]                    status_o
);

  localparam int SW = imh_pkg::SLOT_W;
  localparam int AW = imh_pkg::ADDR_W;

  // control state
  imh_pkg::state_e              state_q, state_d;
  logic [SW-1:0]                size_q, size_d;
  logic [imh_pkg::ID_COUNT-1:0] present_q, present_d;

  // item and walk registers
  logic                         func_q, func_d;
  logic [imh_pkg::ID_W-1:0]     id_q, id_d;
  logic                         tag_q, tag_d;
  imh_pkg::status_e             status_q, status_d;
  imh_pkg::entry_t              mov_q, mov_d;
  logic [SW-1:0]                hole_q, hole_d;
  logic                         moved_q, moved_d;
  imh_pkg::entry_t              top_q;

  // heap memory: slot s (1-based) lives at address s-1, two read ports
  imh_pkg::entry_t              heap_mem [imh_pkg::CAPACITY];
  logic                         heap_we;
  logic [AW-1:0]                heap_waddr, heap_ra, heap_rb;
  imh_pkg::entry_t              heap_wdata, rd_a_q, rd_b_q;

  // position map: slot-1 of each id, meaningful only where present_q is set
  logic [AW-1:0]                slot_mem [imh_pkg::ID_COUNT];
  logic                         slot_we;
  logic [imh_pkg::ID_W-1:0]     slot_waddr;
  logic [AW-1:0]                slot_wdata, slot_rd_q;

  // walk arithmetic
  logic [SW-1:0]                size_inc, size_dec, parent, grand, dl_slot;
  logic [SW:0]                  cur_child, dl_child, big_slot, big_child;
  logic                         ins_full, ins_dup, up_go, cur_down, dl_down;
  logic                         pick_b, dn_go, dn_more;
  imh_pkg::entry_t              big;

  assign size_inc  = size_q + 1'b1;
  assign size_dec  = size_q - 1'b1;
  assign parent    = hole_q >> 1;
  assign grand     = parent >> 1;
  assign dl_slot   = {1'b0, slot_rd_q} + 1'b1;

  assign ins_full  = (size_q == SW'(imh_pkg::CAPACITY));
  assign ins_dup   = present_q[id_q];

  // sift up: moving entry beats its parent
  assign up_go     = (rd_a_q.id < mov_q.id);

  // sift down: children of the current hole and of a freshly loaded delete slot
  assign cur_child = {hole_q, 1'b0};
  assign dl_child  = {dl_slot, 1'b0};
  assign cur_down  = (cur_child <= {1'b0, size_q});
  assign dl_down   = (dl_child <= {1'b0, size_dec});

  // larger child, right one only if it exists
  assign pick_b    = ((cur_child + 1'b1) <= {1'b0, size_q}) && (rd_b_q.id > rd_a_q.id);
  assign big       = pick_b ? rd_b_q : rd_a_q;
  assign big_slot  = pick_b ? (cur_child + 1'b1) : cur_child;
  assign big_child = {big_slot[SW-1:0], 1'b0};
  assign dn_go     = (big.id > mov_q.id);
  assign dn_more   = (big_child <= {1'b0, size_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imh_pkg::S_IDLE: begin
        if (start) state_d = imh_pkg::S_CHECK;
      end
      imh_pkg::S_CHECK: begin
        if (func_q == imh_pkg::FN_INSERT) begin
          if (ins_full || ins_dup) state_d = imh_pkg::S_RESP;
          else if (size_q != '0)   state_d = imh_pkg::S_UP;
          else                     state_d = imh_pkg::S_PLACE;
        end else begin
          if (!present_q[id_q]) state_d = imh_pkg::S_RESP;
          else                  state_d = imh_pkg::S_DLOAD;
        end
      end
      imh_pkg::S_DLOAD: begin
        // removing the last slot needs no walk
        if (dl_slot == size_q)          state_d = imh_pkg::S_RESP;
        else if ((dl_slot >> 1) != '0)  state_d = imh_pkg::S_UP;
        else if (dl_down)               state_d = imh_pkg::S_DOWN;
        else                            state_d = imh_pkg::S_PLACE;
      end
      imh_pkg::S_UP: begin
        if (up_go) begin
          if (grand != '0) state_d = imh_pkg::S_UP;
          else             state_d = imh_pkg::S_PLACE;
        end else if (func_q == imh_pkg::FN_INSERT || moved_q) begin
          state_d = imh_pkg::S_PLACE;
        end else if (cur_down) begin
          state_d = imh_pkg::S_DOWN;
        end else begin
          state_d = imh_pkg::S_PLACE;
        end
      end
      imh_pkg::S_DOWN: begin
        if (dn_go && dn_more) state_d = imh_pkg::S_DOWN;
        else                  state_d = imh_pkg::S_PLACE;
      end
      imh_pkg::S_PLACE: state_d = imh_pkg::S_RESP;
      imh_pkg::S_RESP:  state_d = imh_pkg::S_IDLE;
      default:          state_d = imh_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    size_d     = size_q;
    present_d  = present_q;
    func_d     = func_q;
    id_d       = id_q;
    tag_d      = tag_q;
    status_d   = status_q;
    mov_d      = mov_q;
    hole_d     = hole_q;
    moved_d    = moved_q;
    heap_we    = 1'b0;
    heap_waddr = AW'(hole_q - 1'b1);
    heap_wdata = mov_q;
    heap_ra    = '0;
    heap_rb    = '0;
    slot_we    = 1'b0;
    slot_waddr = mov_q.id;
    slot_wdata = AW'(hole_q - 1'b1);
    unique case (state_q)
      imh_pkg::S_IDLE: begin
        if (start) begin
          func_d   = func_i;
          id_d     = item_id_i;
          tag_d    = tag_bit_i;
          status_d = imh_pkg::ST_OK;
        end
      end
      imh_pkg::S_CHECK: begin
        if (func_q == imh_pkg::FN_INSERT) begin
          if (ins_full) begin
            status_d = imh_pkg::ST_FULL;
          end else if (ins_dup) begin
            status_d = imh_pkg::ST_DUP;
          end else begin
            size_d          = size_inc;
            present_d[id_q] = 1'b1;
            hole_d          = size_inc;
            mov_d           = '{tag: tag_q, id: id_q};
            moved_d         = 1'b0;
            heap_ra         = AW'((size_inc >> 1) - 1'b1);
          end
        end else begin
          if (!present_q[id_q]) begin
            status_d = imh_pkg::ST_ABSENT;
          end else begin
            // fetch the last entry, slot lookup reads id_q
            heap_ra = AW'(size_dec);
          end
        end
      end
      imh_pkg::S_DLOAD: begin
        present_d[id_q] = 1'b0;
        size_d          = size_dec;
        if (dl_slot != size_q) begin
          mov_d   = rd_a_q;
          hole_d  = dl_slot;
          moved_d = 1'b0;
          if ((dl_slot >> 1) != '0) begin
            heap_ra = AW'((dl_slot >> 1) - 1'b1);
          end else begin
            heap_ra = AW'(dl_child - 1'b1);
            heap_rb = AW'(dl_child);
          end
        end
      end
      imh_pkg::S_UP: begin
        if (up_go) begin
          // parent drops into the hole
          heap_we    = 1'b1;
          heap_wdata = rd_a_q;
          slot_we    = 1'b1;
          slot_waddr = rd_a_q.id;
          hole_d     = parent;
          moved_d    = 1'b1;
          heap_ra    = AW'(grand - 1'b1);
        end else begin
          heap_ra = AW'(cur_child - 1'b1);
          heap_rb = AW'(cur_child);
        end
      end
      imh_pkg::S_DOWN: begin
        if (dn_go) begin
          // larger child rises into the hole
          heap_we    = 1'b1;
          heap_wdata = big;
          slot_we    = 1'b1;
          slot_waddr = big.id;
          hole_d     = big_slot[SW-1:0];
          heap_ra    = AW'(big_child - 1'b1);
          heap_rb    = AW'(big_child);
        end
      end
      imh_pkg::S_PLACE: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
      end
      imh_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= imh_pkg::S_IDLE;
      size_q    <= '0;
      present_q <= '0;
    end else begin
      state_q   <= state_d;
      size_q    <= size_d;
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    id_q     <= id_d;
    tag_q    <= tag_d;
    status_q <= status_d;
    mov_q    <= mov_d;
    hole_q   <= hole_d;
    moved_q  <= moved_d;
  end

  // heap memory with registered reads; root copy kept for the result
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    rd_a_q <= heap_mem[heap_ra];
    rd_b_q <= heap_mem[heap_rb];
  end

  always_ff @(posedge clk_i) begin
    if (heap_we && heap_waddr == '0) top_q <= heap_wdata;
  end

  // position map memory
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd_q <= slot_mem[id_q];
  end

  // result ports, valid while done_o is high
  assign busy          = (state_q != imh_pkg::S_IDLE);
  assign done_o        = (state_q == imh_pkg::S_RESP);
  assign top_valid_o   = (size_q != '0);
  assign top_id_o      = top_valid_o ? top_q.id : '0;
  assign top_tag_o     = top_valid_o ? top_q.tag : 1'b0;
  assign entry_count_o = imh_pkg::COUNT_W'(size_q);
  assign status_o      = status_q;

endmodule
